[design/hjtc_pkg.sv]
// Shared constants, types and register indexes of the headset jack type classifier.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps

package hjtc_pkg;

	// Sizing of the zone table and the data fields.
	localparam int MAX_ZONES     = 10;
	localparam int ADC_BITS      = 12;
	localparam int ZONES_PER_REG = 5;
	localparam int HIT_BITS      = 7;
	localparam int LIMIT_BITS    = 6;
	localparam int CODE_BITS     = 4;
	localparam int ZONE_CNT_BITS = 4;

	localparam int BOUNDS_W = ZONES_PER_REG * ADC_BITS;
	localparam int LIMITS_W = MAX_ZONES * LIMIT_BITS;
	localparam int CODES_W  = MAX_ZONES * CODE_BITS;

	// Configuration port sizing.
	localparam int CFG_DATA_W = 60;
	localparam int CFG_IDX_W  = 3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DETECT_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_FIRST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIT_LIMITS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_CODES    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NO_DEVICE     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FOUR_POLE     = 3'd7;

	// Input command codes.
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Saturation value of a zone hit counter.
	localparam logic [HIT_BITS-1:0] HIT_MAX = '1;

	// Per-item control broadcast to every zone cell.
	typedef struct packed {
		logic [ADC_BITS-1:0] adc;
		logic                clear;
		logic                update;
	} cell_ctl_t;

	// Data handed from one zone cell to the next.
	typedef struct packed {
		logic                 taken;
		logic                 fire;
		logic [CODE_BITS-1:0] code;
	} chain_t;

	// One result item.
	typedef struct packed {
		logic [CODE_BITS-1:0] hs_type;
		logic                 type_changed;
		logic                 send_key_enabled;
	} out_item_t;

endpackage

[design/hjtc_in_if.sv]
// Input channel of the classifier: handshake plus the fields of one sample item.
// Depends on hjtc_pkg.
`timescale 1ns / 1ps

interface hjtc_in_if import hjtc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                command;
	logic                detect_level;
	logic [ADC_BITS-1:0] adc_value;

	modport source (output valid, command, detect_level, adc_value, input ready);
	modport sink (input valid, command, detect_level, adc_value, output ready);
endinterface

[design/hjtc_out_if.sv]
// Result channel of the classifier: handshake plus the fields of one decision.
// Depends on hjtc_pkg.
`timescale 1ns / 1ps

interface hjtc_out_if import hjtc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] hs_type;
	logic                 type_changed;
	logic                 send_key_enabled;

	modport source (output valid, hs_type, type_changed, send_key_enabled, input ready);
	modport sink (input valid, hs_type, type_changed, send_key_enabled, output ready);
endinterface

[design/hjtc_zone_cell.sv]
// One ADC zone of the classifier chain: holds the zone's hit counter and passes
// the first-match decision on to the next zone. Depends on hjtc_pkg.
`timescale 1ns / 1ps

module hjtc_zone_cell import hjtc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctl_t             ctl,
	input  logic                  in_use,
	input  logic [ADC_BITS-1:0]   bound,
	input  logic [LIMIT_BITS-1:0] limit,
	input  logic [CODE_BITS-1:0]  code,
	input  chain_t                chain_in,
	output chain_t                chain_out
);

	logic [HIT_BITS-1:0] hits_q;
	logic [HIT_BITS-1:0] base;
	logic [HIT_BITS-1:0] bumped;
	logic                match;
	logic                over;

	// The sample lands here only if no lower zone took it.
	always_comb begin
		base   = ctl.clear ? '0 : hits_q;
		bumped = (base == HIT_MAX) ? base : base + 1'b1;
		match  = in_use && !chain_in.taken && (ctl.adc <= bound);
		over   = bumped > HIT_BITS'(limit);
	end

	// Pass the decision down the chain.
	always_comb begin
		chain_out.taken = chain_in.taken | match;
		chain_out.fire  = chain_in.fire | (match & over);
		chain_out.code  = match ? code : chain_in.code;
	end

	// Hit counter, changed only on an update: cleared on a start, bumped when this zone matches.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
		end else if (ctl.update) begin
			if (match) begin
				hits_q <= bumped;
			end else if (ctl.clear) begin
				hits_q <= '0;
			end
		end
	end

endmodule

[design/hjtc_out_buf.sv]
// Two-entry result buffer (output register plus skid register) that lets the
// classifier take a new item while a result waits. Depends on hjtc_pkg, hjtc_out_if.
`timescale 1ns / 1ps

module hjtc_out_buf import hjtc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  out_item_t  push_item,
	output logic       can_take,
	hjtc_out_if.source result_out
);

	out_item_t out_q;
	out_item_t skid_q;
	logic      out_v_q;
	logic      skid_v_q;
	logic      pop;

	assign pop      = out_v_q && result_out.ready;
	assign can_take = !skid_v_q;

	// Drive the result channel from the output register.
	assign result_out.valid            = out_v_q;
	assign result_out.hs_type          = out_q.hs_type;
	assign result_out.type_changed     = out_q.type_changed;
	assign result_out.send_key_enabled = out_q.send_key_enabled;

	// Valid flags of both entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push && out_v_q && !pop) begin
			skid_v_q <= 1'b1;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// Payload of both entries.
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push && out_v_q && !pop) begin
			skid_q <= push_item;
		end else if (push) begin
			out_q <= push_item;
		end
	end

	// The skid entry is only ever filled behind a waiting output entry.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid without output entry");

	// No push may arrive while the skid entry is occupied.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !push)
		else $error("result pushed into a full buffer");

	// A parked result moves up to the output entry once the output is taken.
	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && pop) |=> (out_v_q && out_q == $past(skid_q)))
		else $error("skid entry lost on transfer");

endmodule

[design/headset_jack_type_classifier.sv]
// Top level of the headset jack type classifier: configuration registers, the
// chain of zone cells and the result buffer. Depends on hjtc_pkg, the channel
// interfaces, hjtc_zone_cell and hjtc_out_buf.
//
//   Channel      Direction  Contents
//   item_in      in         command, detect_level, adc_value
//   result_out   out        hs_type, type_changed, send_key_enabled
//   cfg_*        in         write enable, register index, write data
//
// One item is taken every cycle; its decision is made in the cycle of the
// transfer by the ten zone cells, which compare in parallel and settle the
// first match along the chain, so the next item sees the updated counters.
// Each result is registered in the result buffer before it appears on result_out.
// Reset clears the counters, the reported type and the send-key enable.
// item_in stalls only when both entries of the result buffer are full.
`timescale 1ns / 1ps

module headset_jack_type_classifier import hjtc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hjtc_in_if.sink               item_in,
	hjtc_out_if.source            result_out
);

	// Configuration registers.
	logic [ZONE_CNT_BITS-1:0] zone_cnt_q;
	logic                     det_high_q;
	logic [BOUNDS_W-1:0]      bounds_first_q;
	logic [BOUNDS_W-1:0]      bounds_second_q;
	logic [LIMITS_W-1:0]      limits_q;
	logic [CODES_W-1:0]       codes_q;
	logic [CODE_BITS-1:0]     no_dev_q;
	logic [CODE_BITS-1:0]     four_pole_q;

	// Classifier state.
	logic                 classifying_q;
	logic [CODE_BITS-1:0] reported_q;
	logic                 send_key_q;

	logic                 acc;
	logic                 start;
	logic                 present;
	logic                 active;
	logic                 can_take;
	logic                 push;
	logic [CODE_BITS-1:0] rep_type;
	logic                 changed;
	logic                 send_next;
	cell_ctl_t            ctl;
	chain_t               chain [MAX_ZONES+1];
	out_item_t            push_item;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_cnt_q      <= '0;
			det_high_q      <= 1'b1;
			bounds_first_q  <= '0;
			bounds_second_q <= '0;
			limits_q        <= '0;
			codes_q         <= '0;
			no_dev_q        <= '0;
			four_pole_q     <= CODE_BITS'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ZONE_COUNT:    zone_cnt_q      <= cfg_data[ZONE_CNT_BITS-1:0];
				REG_DETECT_HIGH:   det_high_q      <= cfg_data[0];
				REG_BOUNDS_FIRST:  bounds_first_q  <= cfg_data[BOUNDS_W-1:0];
				REG_BOUNDS_SECOND: bounds_second_q <= cfg_data[BOUNDS_W-1:0];
				REG_HIT_LIMITS:    limits_q        <= cfg_data[LIMITS_W-1:0];
				REG_TYPE_CODES:    codes_q         <= cfg_data[CODES_W-1:0];
				REG_NO_DEVICE:     no_dev_q        <= cfg_data[CODE_BITS-1:0];
				REG_FOUR_POLE:     four_pole_q     <= cfg_data[CODE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Item decode: a sample counts only while classifying.
	assign item_in.ready = can_take;
	assign acc     = item_in.valid && can_take;
	assign start   = (item_in.command == CMD_START);
	assign present = (item_in.detect_level == det_high_q);
	assign active  = acc && (start || classifying_q);

	always_comb begin
		ctl.adc    = item_in.adc_value;
		ctl.clear  = start;
		ctl.update = active && present;
	end

	// Chain of zone cells, zone 0 first.
	assign chain[0] = '0;

	for (genvar z = 0; z < MAX_ZONES; z++) begin : g_zone
		logic [ADC_BITS-1:0] bound;
		logic                in_use;

		if (z < ZONES_PER_REG) begin : g_lo
			assign bound = bounds_first_q[z*ADC_BITS +: ADC_BITS];
		end else begin : g_hi
			assign bound = bounds_second_q[(z-ZONES_PER_REG)*ADC_BITS +: ADC_BITS];
		end

		assign in_use = (ZONE_CNT_BITS'(z) < zone_cnt_q);

		hjtc_zone_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.in_use    (in_use),
			.bound     (bound),
			.limit     (limits_q[z*LIMIT_BITS +: LIMIT_BITS]),
			.code      (codes_q[z*CODE_BITS +: CODE_BITS]),
			.chain_in  (chain[z]),
			.chain_out (chain[z+1])
		);
	end

	// Decision: absent jack reports no device, else the chain end may fire.
	always_comb begin
		push      = active && (!present || chain[MAX_ZONES].fire);
		rep_type  = present ? chain[MAX_ZONES].code : no_dev_q;
		changed   = (rep_type != reported_q);
		send_next = changed ? (rep_type == four_pole_q) : send_key_q;

		push_item.hs_type          = rep_type;
		push_item.type_changed     = changed;
		push_item.send_key_enabled = send_next;
	end

	// Classifier state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			classifying_q <= 1'b0;
			reported_q    <= '0;
			send_key_q    <= 1'b0;
		end else if (active) begin
			classifying_q <= !push;
			if (push) begin
				reported_q <= rep_type;
				send_key_q <= send_next;
			end
		end
	end

	hjtc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.can_take   (can_take),
		.result_out (result_out)
	);

	// A decision always ends classification.
	a_decision_ends: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !classifying_q)
		else $error("still classifying after a decision");

	// After a type change the send-key enable follows the 4-pole code.
	a_send_key_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && changed) |=> (send_key_q == (reported_q == four_pole_q)))
		else $error("send-key enable out of step with reported type");

	// A sample while idle never yields a result.
	a_idle_sample_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && item_in.command == CMD_SAMPLE && !classifying_q) |-> !push)
		else $error("result from a sample while idle");

endmodule
